// ===== sv/ffha_pkg.sv =====
// Shared types and constants of the first-fit heap allocator.
package ffha_pkg;

	localparam int unsigned HDR_BYTES  = 25;
	localparam int unsigned MAX_BLOCKS = 64;
	localparam int unsigned IDX_W      = 6;
	localparam int unsigned CNT_W      = 7;
	localparam int unsigned SIZE_W     = 17;
	localparam int unsigned ADDR_W     = 16;

	localparam logic [SIZE_W-1:0] LEN_RESET = 17'd4096;
	localparam logic [SIZE_W-1:0] LEN_LOW   = 17'd64;
	localparam logic [SIZE_W-1:0] LEN_HIGH  = 17'd65536;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_FIT   = 2'd1;
	localparam logic [1:0] ST_BAD_FREE = 2'd2;
	localparam logic [1:0] ST_ZERO     = 2'd3;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [SIZE_W-1:0] size;
		logic              free;
	} blk_t;

endpackage

// ===== sv/ffha_if.sv =====
// Request and response channel interfaces of the allocator.
interface ffha_req_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [16:0] count;
	logic [15:0] address;

	modport source (output valid, cmd, count, address, input ready);
	modport sink (input valid, cmd, count, address, output ready);
endinterface

interface ffha_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] address_res;
	logic [16:0] granted_size;

	modport source (output valid, status, address_res, granted_size, input ready);
	modport sink (input valid, status, address_res, granted_size, output ready);
endinterface

// ===== sv/first_fit_heap_allocator.sv =====
// First-fit heap allocator with coalescing: top level and sequencer.
//
// The req channel carries one command per beat: allocate (cmd 0, count bytes)
// or free (cmd 1, payload address). The rsp channel returns exactly one beat
// per command with status, granted payload address and payload size.
// The block table lives in a single-port-write, registered-read memory, and
// one small sequencer walks it entry by entry. A scan reads and evaluates
// one table entry at a time; a split shifts the entries above the hit up by
// one, and a free with coalescing shifts entries down by one or two places.
// req.ready is high only while the sequencer is idle.
// The result is held in an output register; a finished command waits there
// while rsp.ready is low, and the next command is accepted meanwhile, but
// its own result waits until the register frees up.
// After reset, and after every write of heap_len through cfg_we/cfg_wdata,
// the table is rebuilt as one free block while req.ready stays low.
// heap_len resets to 4096 and is clamped to 64..65536.
module first_fit_heap_allocator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [16:0]         cfg_wdata,
	ffha_req_if.sink            req,
	ffha_rsp_if.source          rsp
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SC_RD  = 4'd1;
	localparam logic [3:0] S_SC_EV  = 4'd2;
	localparam logic [3:0] S_SH_RD  = 4'd3;
	localparam logic [3:0] S_SH_WR  = 4'd4;
	localparam logic [3:0] S_SP_NEW = 4'd5;
	localparam logic [3:0] S_SP_CUR = 4'd6;
	localparam logic [3:0] S_FL_RD  = 4'd7;
	localparam logic [3:0] S_FL_EV  = 4'd8;
	localparam logic [3:0] S_FR_RD  = 4'd9;
	localparam logic [3:0] S_FR_EV  = 4'd10;
	localparam logic [3:0] S_FR_WR  = 4'd11;
	localparam logic [3:0] S_MV_RD  = 4'd12;
	localparam logic [3:0] S_MV_WR  = 4'd13;
	localparam logic [3:0] S_RESP   = 4'd14;

	localparam logic [16:0] HDR17 = 17'(ffha_pkg::HDR_BYTES);
	localparam logic [15:0] HDR16 = 16'(ffha_pkg::HDR_BYTES);
	localparam logic [6:0]  MAXB  = 7'(ffha_pkg::MAX_BLOCKS);

	logic [3:0]           state_q;
	logic                 init_q;
	logic [16:0]          heap_len_q;
	logic [6:0]           cnt_q;
	logic                 cmd_q;
	logic [16:0]          count_q;
	logic [15:0]          addr_q;
	logic [6:0]           i_q;
	logic [6:0]           k_q;
	logic [6:0]           d_q;
	logic [1:0]           n_q;
	ffha_pkg::blk_t       cur_q;
	logic [16:0]          acc_q;
	logic [15:0]          dstart_q;
	logic                 lfree_q;
	logic [1:0]           status_q;
	logic [15:0]          ares_q;
	logic [16:0]          gsize_q;

	logic                 ov_q;
	logic [1:0]           ostatus_q;
	logic [15:0]          oares_q;
	logic [16:0]          ogsize_q;

	logic                 we;
	logic [5:0]           waddr;
	ffha_pkg::blk_t       wdata;
	logic [5:0]           raddr;
	ffha_pkg::blk_t       rdata;

	logic [16:0]          cfg_len;
	logic [16:0]          rem;
	logic                 hit;
	logic [7:0]           mv_src;

	ffha_tbl u_tbl (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign req.ready        = (state_q == S_IDLE) && !init_q;
	assign rsp.valid        = ov_q;
	assign rsp.status       = ostatus_q;
	assign rsp.address_res  = oares_q;
	assign rsp.granted_size = ogsize_q;

	always_comb begin
		cfg_len = cfg_wdata;
		if (cfg_wdata < ffha_pkg::LEN_LOW) begin
			cfg_len = ffha_pkg::LEN_LOW;
		end else if (cfg_wdata > ffha_pkg::LEN_HIGH) begin
			cfg_len = ffha_pkg::LEN_HIGH;
		end
	end

	assign rem    = rdata.size - count_q;
	assign mv_src = {1'b0, k_q} + {6'd0, n_q};

	// An allocate hits the first free block that is large enough; a free hits
	// the block whose payload offset equals the address.
	always_comb begin
		if (cmd_q == ffha_pkg::CMD_ALLOC) begin
			hit = rdata.free && (rdata.size >= count_q);
		end else begin
			hit = ({1'b0, rdata.start} + HDR17) == {1'b0, addr_q};
		end
	end

	// Memory port control.
	always_comb begin
		we    = 1'b0;
		waddr = i_q[5:0];
		wdata = rdata;
		raddr = i_q[5:0];
		unique case (state_q)
			S_IDLE: begin
				we          = init_q;
				waddr       = '0;
				wdata.start = '0;
				wdata.size  = heap_len_q - HDR17;
				wdata.free  = 1'b1;
			end
			S_SC_EV: begin
				we         = hit && (cmd_q == ffha_pkg::CMD_ALLOC) &&
					!((rem > HDR17) && (cnt_q < MAXB));
				wdata.free = 1'b0;
			end
			S_SH_RD: raddr = 6'(k_q - 7'd1);
			S_SH_WR: begin
				we    = 1'b1;
				waddr = k_q[5:0];
			end
			S_SP_NEW: begin
				we          = 1'b1;
				waddr       = 6'(i_q + 7'd1);
				wdata.start = cur_q.start + HDR16 + count_q[15:0];
				wdata.size  = cur_q.size - count_q - HDR17;
				wdata.free  = 1'b1;
			end
			S_SP_CUR: begin
				we          = 1'b1;
				wdata.start = cur_q.start;
				wdata.size  = count_q;
				wdata.free  = 1'b0;
			end
			S_FL_RD: raddr = 6'(i_q - 7'd1);
			S_FR_RD: raddr = 6'(i_q + 7'd1);
			S_FR_WR: begin
				we          = 1'b1;
				waddr       = d_q[5:0];
				wdata.start = dstart_q;
				wdata.size  = acc_q;
				wdata.free  = 1'b1;
			end
			S_MV_RD: raddr = mv_src[5:0];
			S_MV_WR: begin
				we    = 1'b1;
				waddr = k_q[5:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			init_q     <= 1'b1;
			heap_len_q <= ffha_pkg::LEN_RESET;
			cnt_q      <= 7'd1;
			ov_q       <= 1'b0;
		end else begin
			// A beat leaving in the same cycle as a new result is loaded keeps
			// the register full, so the clear is skipped while loading.
			if (rsp.valid && rsp.ready && state_q != S_RESP) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (init_q) begin
						cnt_q <= 7'd1;
					end else if (req.valid) begin
						cmd_q    <= req.cmd;
						count_q  <= req.count;
						addr_q   <= req.address;
						i_q      <= '0;
						status_q <= ffha_pkg::ST_OK;
						ares_q   <= '0;
						gsize_q  <= '0;
						if (req.cmd == ffha_pkg::CMD_ALLOC && req.count == '0) begin
							status_q <= ffha_pkg::ST_ZERO;
							state_q  <= S_RESP;
						end else if (req.cmd == ffha_pkg::CMD_FREE && req.address == '0) begin
							state_q <= S_RESP;
						end else begin
							state_q <= S_SC_RD;
						end
					end
				end
				S_SC_RD: begin
					if (i_q == cnt_q) begin
						status_q <= (cmd_q == ffha_pkg::CMD_ALLOC) ?
							ffha_pkg::ST_NO_FIT : ffha_pkg::ST_BAD_FREE;
						state_q  <= S_RESP;
					end else begin
						state_q <= S_SC_EV;
					end
				end
				S_SC_EV: begin
					if (!hit) begin
						i_q     <= i_q + 7'd1;
						state_q <= S_SC_RD;
					end else if (cmd_q == ffha_pkg::CMD_ALLOC) begin
						ares_q <= rdata.start + HDR16;
						cur_q  <= rdata;
						if ((rem > HDR17) && (cnt_q < MAXB)) begin
							gsize_q <= count_q;
							k_q     <= cnt_q;
							state_q <= S_SH_RD;
						end else begin
							gsize_q <= rdata.size;
							state_q <= S_RESP;
						end
					end else if (rdata.free) begin
						status_q <= ffha_pkg::ST_BAD_FREE;
						state_q  <= S_RESP;
					end else begin
						acc_q    <= rdata.size;
						dstart_q <= rdata.start;
						d_q      <= i_q;
						lfree_q  <= 1'b0;
						n_q      <= 2'd0;
						state_q  <= (i_q != '0) ? S_FL_RD : S_FR_RD;
					end
				end
				S_SH_RD: begin
					state_q <= (k_q == i_q + 7'd1) ? S_SP_NEW : S_SH_WR;
				end
				S_SH_WR: begin
					k_q     <= k_q - 7'd1;
					state_q <= S_SH_RD;
				end
				S_SP_NEW: state_q <= S_SP_CUR;
				S_SP_CUR: begin
					cnt_q   <= cnt_q + 7'd1;
					state_q <= S_RESP;
				end
				S_FL_RD: state_q <= S_FL_EV;
				S_FL_EV: begin
					if (rdata.free) begin
						acc_q    <= acc_q + rdata.size + HDR17;
						dstart_q <= rdata.start;
						d_q      <= i_q - 7'd1;
						lfree_q  <= 1'b1;
						n_q      <= 2'd1;
					end
					state_q <= S_FR_RD;
				end
				S_FR_RD: begin
					state_q <= (i_q + 7'd1 < cnt_q) ? S_FR_EV : S_FR_WR;
				end
				S_FR_EV: begin
					if (rdata.free) begin
						acc_q <= acc_q + rdata.size + HDR17;
						n_q   <= n_q + 2'd1;
					end
					state_q <= S_FR_WR;
				end
				S_FR_WR: begin
					gsize_q <= acc_q;
					// Entries above the merged block close the gap of one or two slots.
					k_q     <= lfree_q ? i_q : i_q + 7'd1;
					state_q <= (n_q == 2'd0) ? S_RESP : S_MV_RD;
				end
				S_MV_RD: begin
					if (mv_src >= {1'b0, cnt_q}) begin
						cnt_q   <= cnt_q - {5'd0, n_q};
						state_q <= S_RESP;
					end else begin
						state_q <= S_MV_WR;
					end
				end
				S_MV_WR: begin
					k_q     <= k_q + 7'd1;
					state_q <= S_MV_RD;
				end
				S_RESP: begin
					if (!ov_q || rsp.ready) begin
						ov_q      <= 1'b1;
						ostatus_q <= status_q;
						oares_q   <= ares_q;
						ogsize_q  <= gsize_q;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (cfg_we) begin
				heap_len_q <= cfg_len;
				init_q     <= 1'b1;
			end else if (init_q && state_q == S_IDLE) begin
				init_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/ffha_tbl.sv =====
// Block table storage: one write port and one registered read port.
module ffha_tbl (
	input  logic                         clk,
	input  logic                         we,
	input  logic [ffha_pkg::IDX_W-1:0]   waddr,
	input  ffha_pkg::blk_t               wdata,
	input  logic [ffha_pkg::IDX_W-1:0]   raddr,
	output ffha_pkg::blk_t               rdata
);

	ffha_pkg::blk_t mem_q [ffha_pkg::MAX_BLOCKS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== tb/ffha_checker.sv =====
// Scoreboard for the allocator: tracks the block table, predicts each response beat and compares.
module ffha_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [16:0] cfg_wdata,
	ffha_req_if         req,
	ffha_rsp_if         rsp,
	output int          fails,
	output int          pending
);

	typedef struct {
		logic [1:0]  status;
		logic [15:0] address_res;
		logic [16:0] granted_size;
	} alloc_result_t;

	alloc_result_t expected_results[$];

	int unsigned blk_start[ffha_pkg::MAX_BLOCKS];
	int unsigned blk_size[ffha_pkg::MAX_BLOCKS];
	bit          blk_free[ffha_pkg::MAX_BLOCKS];
	int unsigned blk_count;
	int unsigned arena_len;

	function automatic void rebuild_table(input int unsigned len);
		arena_len = len;
		for (int k = 0; k < ffha_pkg::MAX_BLOCKS; k++) begin
			blk_start[k] = 0;
			blk_size[k]  = 0;
			blk_free[k]  = 0;
		end
		blk_size[0] = (len > ffha_pkg::HDR_BYTES) ? len - ffha_pkg::HDR_BYTES : 0;
		blk_free[0] = 1;
		blk_count   = 1;
	endfunction

	// Folds entry i + 1 into entry i and closes the gap.
	function automatic void join_next(input int unsigned i);
		blk_size[i] += ffha_pkg::HDR_BYTES + blk_size[i+1];
		for (int unsigned k = i + 1; k + 1 < blk_count; k++) begin
			blk_start[k] = blk_start[k+1];
			blk_size[k]  = blk_size[k+1];
			blk_free[k]  = blk_free[k+1];
		end
		blk_count--;
	endfunction

	function automatic alloc_result_t serve_request(input logic c, input logic [16:0] cnt,
			input logic [15:0] a);
		alloc_result_t r;
		int unsigned i;
		r = '{ffha_pkg::ST_OK, 16'd0, 17'd0};
		if (c == ffha_pkg::CMD_ALLOC) begin
			if (cnt == 0) begin
				r.status = ffha_pkg::ST_ZERO;
			end else begin
				for (i = 0; i < blk_count; i++)
					if (blk_free[i] && blk_size[i] >= cnt) break;
				if (i >= blk_count) begin
					r.status = ffha_pkg::ST_NO_FIT;
				end else begin
					if (blk_size[i] - cnt > ffha_pkg::HDR_BYTES &&
						blk_count < ffha_pkg::MAX_BLOCKS) begin
						for (int unsigned k = blk_count; k > i + 1; k--) begin
							blk_start[k] = blk_start[k-1];
							blk_size[k]  = blk_size[k-1];
							blk_free[k]  = blk_free[k-1];
						end
						blk_start[i+1] = blk_start[i] + ffha_pkg::HDR_BYTES + cnt;
						blk_size[i+1]  = blk_size[i] - cnt - ffha_pkg::HDR_BYTES;
						blk_free[i+1]  = 1;
						blk_count++;
						blk_size[i] = cnt;
					end
					blk_free[i]    = 0;
					r.address_res  = 16'(blk_start[i] + ffha_pkg::HDR_BYTES);
					r.granted_size = 17'(blk_size[i]);
				end
			end
		end else if (a != 0) begin
			for (i = 0; i < blk_count; i++)
				if (blk_start[i] + ffha_pkg::HDR_BYTES == a) break;
			if (i >= blk_count || blk_free[i]) begin
				r.status = ffha_pkg::ST_BAD_FREE;
			end else begin
				blk_free[i] = 1;
				if (i > 0 && blk_free[i-1]) begin
					join_next(i - 1);
					i--;
				end
				if (i + 1 < blk_count && blk_free[i+1]) join_next(i);
				r.granted_size = 17'(blk_size[i]);
			end
		end
		return r;
	endfunction

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t e;
		if (!arst_n) begin
			expected_results.delete();
			fails = 0;
			rebuild_table(ffha_pkg::LEN_RESET);
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					$error("response beat with no request outstanding");
					fails++;
				end else begin
					e = expected_results.pop_front();
					if (rsp.status !== e.status) begin
						$error("status: expected %0d, got %0d", e.status, rsp.status);
						fails++;
					end
					if (rsp.address_res !== e.address_res) begin
						$error("address_res: expected %0d, got %0d", e.address_res,
							rsp.address_res);
						fails++;
					end
					if (rsp.granted_size !== e.granted_size) begin
						$error("granted_size: expected %0d, got %0d", e.granted_size,
							rsp.granted_size);
						fails++;
					end
				end
			end
			if (cfg_we) begin
				if (cfg_wdata < ffha_pkg::LEN_LOW) rebuild_table(ffha_pkg::LEN_LOW);
				else if (cfg_wdata > ffha_pkg::LEN_HIGH) rebuild_table(ffha_pkg::LEN_HIGH);
				else rebuild_table(cfg_wdata);
			end
			if (req.valid && req.ready)
				expected_results.push_back(serve_request(req.cmd, req.count, req.address));
		end
	end

endmodule

// ===== tb/first_fit_heap_allocator_tb.sv =====
// Testbench top for the first-fit heap allocator: stimulus, flow control and verdict.
module first_fit_heap_allocator_tb;

	localparam int DRAIN_CYCLES = 300;
	localparam int CYCLE_LIMIT  = 3000000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [16:0] cfg_wdata;
	int          fails;
	int          pending;
	int          cycles = 0;
	bit          steady;
	int unsigned cur_len;
	logic [15:0] live_addrs[$];

	ffha_req_if req ();
	ffha_rsp_if rsp ();

	first_fit_heap_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp)
	);

	ffha_checker scoreboard (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp),
		.fails     (fails),
		.pending   (pending)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// A long window with no stalls on either side.
	assign steady = (cycles >= 30000 && cycles < 90000);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("first_fit_heap_allocator_tb: FAIL");
			$finish;
		end
	end

	always @(negedge clk)
		rsp.ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 29);

	// Granted addresses feed later frees.
	always @(posedge clk)
		if (rsp.valid && rsp.ready && rsp.status == ffha_pkg::ST_OK && rsp.address_res != 0)
			live_addrs.push_back(rsp.address_res);

	task automatic send_beat(input logic c, input logic [16:0] cnt, input logic [15:0] a);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 29) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid   <= 1'b1;
		req.cmd     <= c;
		req.count   <= cnt;
		req.address <= a;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	task automatic drain_all;
		@(negedge clk);
		req.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_heap_len(input logic [16:0] v);
		drain_all();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		live_addrs.delete();
		cur_len = (v < ffha_pkg::LEN_LOW) ? ffha_pkg::LEN_LOW :
			(v > ffha_pkg::LEN_HIGH) ? ffha_pkg::LEN_HIGH : v;
	endtask

	task automatic free_live;
		int idx;
		logic [15:0] a;
		if (live_addrs.size() == 0) begin
			send_beat(ffha_pkg::CMD_FREE, 17'($urandom), 16'($urandom));
		end else begin
			idx = $urandom_range(0, live_addrs.size() - 1);
			a = live_addrs[idx];
			live_addrs.delete(idx);
			send_beat(ffha_pkg::CMD_FREE, 17'($urandom), a);
		end
	endtask

	task automatic random_phase(input int n);
		int r;
		int unsigned top_cnt;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			top_cnt = (cur_len / 6 > 1) ? cur_len / 6 : 1;
			if (r < 50)
				send_beat(ffha_pkg::CMD_ALLOC, 17'($urandom_range(1, top_cnt)), 16'($urandom));
			else if (r < 54)
				send_beat(ffha_pkg::CMD_ALLOC, 17'($urandom_range(1, 40)), 16'($urandom));
			else if (r < 57)
				send_beat(ffha_pkg::CMD_ALLOC, 17'($urandom), 16'($urandom));
			else if (r < 59)
				send_beat(ffha_pkg::CMD_ALLOC, 17'd0, 16'($urandom));
			else if (r < 92)
				free_live();
			else if (r < 94)
				send_beat(ffha_pkg::CMD_FREE, 17'($urandom), 16'd0);
			else
				send_beat(ffha_pkg::CMD_FREE, 17'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		req.valid = 1'b0;
		req.cmd   = ffha_pkg::CMD_ALLOC;
		req.count = '0;
		req.address = '0;
		cur_len   = ffha_pkg::LEN_RESET;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: zero count, coalescing with the following block, bad frees.
		send_beat(ffha_pkg::CMD_ALLOC, 17'd0, 16'hFFFF);
		send_beat(ffha_pkg::CMD_ALLOC, 17'd1, 16'd0);
		send_beat(ffha_pkg::CMD_ALLOC, 17'd100, 16'd0);
		send_beat(ffha_pkg::CMD_ALLOC, 17'd200, 16'd0);
		send_beat(ffha_pkg::CMD_FREE, 17'd0, 16'd51);
		send_beat(ffha_pkg::CMD_FREE, 17'd0, 16'd25);
		send_beat(ffha_pkg::CMD_FREE, 17'd0, 16'd25);
		send_beat(ffha_pkg::CMD_FREE, 17'd0, 16'd151);
		send_beat(ffha_pkg::CMD_FREE, 17'd0, 16'd0);
		send_beat(ffha_pkg::CMD_FREE, 17'h1FFFF, 16'hFFFF);
		send_beat(ffha_pkg::CMD_ALLOC, 17'h1FFFF, 16'd0);
		send_beat(ffha_pkg::CMD_ALLOC, 17'd4072, 16'd0);
		send_beat(ffha_pkg::CMD_ALLOC, 17'd4071, 16'd0);
		send_beat(ffha_pkg::CMD_FREE, 17'd0, 16'd25);
		send_beat(ffha_pkg::CMD_ALLOC, 17'd4045, 16'd0);
		send_beat(ffha_pkg::CMD_ALLOC, 17'd1, 16'd0);
		live_addrs.delete();
		random_phase(250);

		write_heap_len(17'd0);
		send_beat(ffha_pkg::CMD_ALLOC, 17'd39, 16'd0);
		send_beat(ffha_pkg::CMD_ALLOC, 17'd1, 16'd0);
		random_phase(200);

		// The largest arena with tiny requests fills the block table.
		write_heap_len(17'h1FFFF);
		for (int k = 0; k < 70; k++)
			send_beat(ffha_pkg::CMD_ALLOC, 17'($urandom_range(1, 30)), 16'd0);
		random_phase(300);

		write_heap_len(17'd1000);
		random_phase(300);
		write_heap_len(17'd65536);
		random_phase(300);
		write_heap_len(17'd63);
		random_phase(300);

		drain_all();
		if (fails == 0)
			$display("first_fit_heap_allocator_tb: PASS");
		else
			$display("first_fit_heap_allocator_tb: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
sv/ffha_pkg.sv
sv/ffha_if.sv
sv/ffha_tbl.sv
sv/first_fit_heap_allocator.sv
tb/ffha_checker.sv
tb/first_fit_heap_allocator_tb.sv
